### hw/rtl/sdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_pkg - shared definitions for the set difference filter
// Table sizing, request codes, controller states and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package sdf_pkg;

  // Exclusion table sizing
  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int VALUE_W     = 32;

  // Input tuser layout: bit 0 operation, bit 1 start_new
  localparam int USER_OP_BIT    = 0;
  localparam int USER_FRESH_BIT = 1;

  // Operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } sdf_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // store input value into the table
    logic capture;     // latch a query and restart the scan
    logic scan_step;   // read the next table entry
    logic emit;        // finish the query, write result if unmatched
  } sdf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic count_zero;  // table is empty
    logic scan_last;   // current read is the last valid entry
    logic out_free;    // output register can take a result
  } sdf_status_t;

endpackage

### hw/rtl/sdf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_ctrl - set difference filter controller
// Accepts requests, sequences the table scan for a query and issues the
// result write once the output register is free.
// ----------------------------------------------------------------------------
module sdf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 op,
  output logic                 s_tready,
  input  sdf_pkg::sdf_status_t status,
  output sdf_pkg::sdf_cmd_t    cmd
);
  import sdf_pkg::*;

  sdf_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid && op == OP_QUERY) begin
          state_next = status.count_zero ? ST_RESULT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    s_tready      = 1'b0;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.load    = s_tvalid && (op == OP_LOAD);
        cmd.capture = s_tvalid && (op == OP_QUERY);
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ST_RESULT: begin
        cmd.emit = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### hw/rtl/sdf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_datapath - set difference filter datapath
// Holds the exclusion table memory, entry count, overflow flag, scan
// counter, comparator and the output register.
// ----------------------------------------------------------------------------
module sdf_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fresh,
  input  logic [sdf_pkg::VALUE_W-1:0]   in_value,
  input  sdf_pkg::sdf_cmd_t             cmd,
  output sdf_pkg::sdf_status_t          status,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [sdf_pkg::VALUE_W-1:0]   kept_value,
  output logic                          table_overflowed
);
  import sdf_pkg::*;

  logic [VALUE_W-1:0] mem [TABLE_DEPTH];

  logic [COUNT_W-1:0] count, count_next, count_eff;
  logic               ovf, ovf_next;
  logic               wr_en;
  logic [VALUE_W-1:0] query;
  logic [ADDR_W-1:0]  idx;
  logic [VALUE_W-1:0] rd_data;
  logic               rd_valid;
  logic               match;

  // Load bookkeeping: start_new empties the table first
  always_comb begin
    count_eff  = fresh ? '0 : count;
    count_next = count;
    ovf_next   = ovf;
    wr_en      = 1'b0;
    if (cmd.load) begin
      ovf_next = fresh ? 1'b0 : ovf;
      if (count_eff < COUNT_W'(TABLE_DEPTH)) begin
        wr_en      = 1'b1;
        count_next = count_eff + COUNT_W'(1);
      end else begin
        count_next = count_eff;
        ovf_next   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      count <= count_next;
      ovf   <= ovf_next;
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_eff[ADDR_W-1:0]] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      rd_data <= mem[idx];
    end
  end

  // Query latch and scan index
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      query <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.capture) begin
      idx <= '0;
    end else if (cmd.scan_step) begin
      idx <= idx + ADDR_W'(1);
    end
  end

  // Compare one entry per cycle, sticky match
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      match    <= 1'b0;
    end else begin
      rd_valid <= cmd.scan_step;
      if (cmd.capture) begin
        match <= 1'b0;
      end else if (rd_valid && rd_data == query) begin
        match <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit && !match) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && !match) begin
      kept_value       <= query;
      table_overflowed <= ovf;
    end
  end

  // Status
  always_comb begin
    status.count_zero = (count == '0);
    status.scan_last  = ((COUNT_W'(idx) + COUNT_W'(1)) == count);
    status.out_free   = !m_tvalid || m_tready;
  end

endmodule

### hw/rtl/set_difference_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_difference_filter - streaming set difference filter
// Loads build an exclusion table; queries pass only if not in the table.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_*) carries requests. s_tuser[0] selects the operation
//   (0 load, 1 query), s_tuser[1] is start_new, s_tdata is the value.
//   A load stores the value in the next free table entry (start_new empties
//   the table and clears the overflow flag first); a load into a full table
//   is dropped and sets the sticky overflow flag.
//   A query reads the N stored entries one per cycle through the single
//   read port of the table memory; with an empty table it skips the scan.
//   No new request is accepted until the query has finished.
//   Master channel (m_*) returns unmatched queries: m_tdata is the value,
//   m_tuser is the overflow flag. Matched queries produce nothing.
//   The result sits in an output register; the next request is accepted
//   while it waits. A query finishing while the receiver still stalls an
//   earlier result holds until the register frees.
//   Reset (rst, synchronous) empties the table, clears the overflow flag
//   and drops any pending result. Table contents are not cleared.
// ----------------------------------------------------------------------------
module set_difference_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [1:0]  s_tuser,   // [0] operation, [1] start_new
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] kept_value
  output logic        m_tuser    // [0] table_overflowed
);
  import sdf_pkg::*;

  sdf_cmd_t    cmd;
  sdf_status_t status;

  sdf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .op       (s_tuser[USER_OP_BIT]),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sdf_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .fresh            (s_tuser[USER_FRESH_BIT]),
    .in_value         (s_tdata),
    .cmd              (cmd),
    .status           (status),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .kept_value       (m_tdata),
    .table_overflowed (m_tuser)
  );

endmodule

### dv/set_difference_filter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_difference_filter_test - self-checking bench for the set difference filter
// Loads build up an exclusion table and queries stream values through it. A
// scoreboard keeps its own copy of the table, count and overflow flag, works
// out which queries must come out, and checks each returned request field by
// field, in order. Directed requests cover the extremes and the special cases;
// after them come random frames (a load burst followed by queries, some
// overfilling the table) mixed with noise. Both sides of the bus idle at
// random, in several phases.
// ----------------------------------------------------------------------------
module set_difference_filter_test;
  import sdf_pkg::*;

  localparam int N_REQUESTS = 1350;
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 40;

  // Expected output request
  typedef struct {
    logic [31:0] kept_value;
    logic        table_overflowed;
  } kept_result_t;

  // Scoreboard: own copy of the exclusion table and the results it implies
  class difference_scoreboard;
    logic [31:0]  excl_table [TABLE_DEPTH];
    int           excl_count;
    logic         excl_overflow;
    kept_result_t kept_q [$];
    int           errors;

    function new();
      excl_count    = 0;
      excl_overflow = 1'b0;
      errors        = 0;
    endfunction

    // Apply one accepted request to the table, queue a result if it passes
    function void note_request(logic op, logic fresh, logic [31:0] value);
      bit           hit;
      kept_result_t res;
      hit = 1'b0;
      if (op == OP_LOAD) begin
        if (fresh) begin
          excl_count    = 0;
          excl_overflow = 1'b0;
        end
        if (excl_count < TABLE_DEPTH) begin
          excl_table[excl_count] = value;
          excl_count++;
        end else begin
          excl_overflow = 1'b1;
        end
      end else begin
        for (int k = 0; k < excl_count; k++)
          if (excl_table[k] == value) hit = 1'b1;
        if (!hit) begin
          res.kept_value       = value;
          res.table_overflowed = excl_overflow;
          kept_q = {kept_q, res};
        end
      end
    endfunction

    // Compare a returned request with the oldest expectation
    function void check_result(logic [31:0] value, logic overflowed);
      kept_result_t exp_res;
      if (kept_q.size() == 0) begin
        $display("%0t: unexpected result kept_value=%h table_overflowed=%b",
                 $time, value, overflowed);
        errors++;
        return;
      end
      exp_res = kept_q.pop_front();
      if (value !== exp_res.kept_value) begin
        $display("%0t: kept_value mismatch: expected %h, actual %h",
                 $time, exp_res.kept_value, value);
        errors++;
      end
      if (overflowed !== exp_res.table_overflowed) begin
        $display("%0t: table_overflowed mismatch: expected %b, actual %b",
                 $time, exp_res.table_overflowed, overflowed);
        errors++;
      end
    endfunction

    function int pending();
      return kept_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] value
  logic [1:0]  s_tuser = '0;   // [0] operation, [1] start_new
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [31:0] kept_value
  logic        m_tuser;        // [0] table_overflowed

  difference_scoreboard sb = new();
  int sent_count = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  set_difference_filter i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: check on handshake, then pick the next stall
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    m_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Send one request, with a random gap ahead of it
  task automatic send_request(input logic op, input logic fresh, input logic [31:0] value);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser[USER_OP_BIT]    <= op;
    s_tuser[USER_FRESH_BIT] <= fresh;
    do @(posedge clk); while (!s_tready);
    sb.note_request(op, fresh, value);
    sent_count++;
  endtask

  // Mostly full-range values; small ones give hits across frames
  function automatic logic [31:0] pick_value();
    int sel;
    sel = $urandom_range(7);
    case (sel)
      0, 1: pick_value = $urandom_range(15) - 8;
      2: begin
        case ($urandom_range(3))
          0: pick_value = 32'h8000_0000;
          1: pick_value = 32'h7FFF_FFFF;
          2: pick_value = 32'hFFFF_FFFF;
          default: pick_value = 32'h0000_0000;
        endcase
      end
      default: pick_value = $urandom();
    endcase
  endfunction

  // Load burst followed by queries, half of them aimed at stored values
  task automatic run_frame(input int n_loads, input bit fresh_first);
    logic [31:0] stored [$];
    logic [31:0] v;
    int n_queries;
    for (int i = 0; i < n_loads; i++) begin
      v = pick_value();
      stored = {stored, v};
      send_request(OP_LOAD, fresh_first && (i == 0), v);
    end
    n_queries = $urandom_range(4, 24);
    for (int i = 0; i < n_queries; i++) begin
      if (stored.size() > 0 && $urandom_range(1))
        v = stored[$urandom_range(stored.size() - 1)];
      else
        v = pick_value();
      send_request(OP_QUERY, 1'($urandom_range(1)), v);
    end
  endtask

  // Wait until every expected result has come back
  task automatic pause_until_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int phase;
    int cur_phase;
    cur_phase = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, extremes, drops, duplicates, start_new on a query
    send_request(OP_QUERY, 1'b0, 32'h0000_0000);
    send_request(OP_QUERY, 1'b0, 32'h8000_0000);
    send_request(OP_QUERY, 1'b1, 32'h7FFF_FFFF);
    send_request(OP_LOAD,  1'b1, 32'h8000_0000);
    send_request(OP_LOAD,  1'b0, 32'h7FFF_FFFF);
    send_request(OP_LOAD,  1'b0, 32'h0000_0000);
    send_request(OP_LOAD,  1'b0, 32'hFFFF_FFFF);
    send_request(OP_QUERY, 1'b0, 32'h8000_0000);
    send_request(OP_QUERY, 1'b1, 32'h7FFF_FFFF);
    send_request(OP_QUERY, 1'b0, 32'hFFFF_FFFF);
    send_request(OP_QUERY, 1'b0, 32'h0000_0001);
    send_request(OP_QUERY, 1'b0, 32'hFFFF_FFFE);
    send_request(OP_QUERY, 1'b0, 32'h0000_0000);
    send_request(OP_QUERY, 1'b0, 32'h0000_0001);
    send_request(OP_LOAD,  1'b1, 32'h5555_5555);
    send_request(OP_QUERY, 1'b0, 32'h8000_0000);
    send_request(OP_QUERY, 1'b0, 32'h5555_5555);
    send_request(OP_QUERY, 1'b1, 32'hAAAA_AAAA);

    // Overfill the table, then a fresh load on the full table
    run_frame(TABLE_DEPTH + 2, 1'b1);
    run_frame(3, 1'b1);

    // Random frames and noise, idle phases by progress
    while (sent_count < N_REQUESTS) begin
      phase = (sent_count * 4) / N_REQUESTS;
      if (phase != cur_phase) begin
        pause_until_drained();
        cur_phase = phase;
        case (phase)
          1: begin sender_idle_pct = 78; receiver_stall_pct = 0; end
          2: begin sender_idle_pct = 0;  receiver_stall_pct = 78; end
          default: begin sender_idle_pct = 30; receiver_stall_pct = 30; end
        endcase
      end
      case ($urandom_range(9))
        0: run_frame($urandom_range(TABLE_DEPTH - 2, TABLE_DEPTH + 4), 1'b1);
        1: repeat ($urandom_range(1, 8))
             send_request(1'($urandom_range(1)), 1'($urandom_range(1)), pick_value());
        2: run_frame($urandom_range(1, 16), 1'b0);
        default: run_frame($urandom_range(1, 16), 1'b1);
      endcase
    end

    // Drain and let any late result show up
    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("set_difference_filter test passed");
    else
      $display("set_difference_filter test failed");
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #20_000_000;
    $display("set_difference_filter test failed");
    $finish;
  end

endmodule
